FILE: sv/scpa_pkg.sv
// Shared types and codes for the size-class pool allocator.
package scpa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_BADSZ = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RD,
    S_POP_WB,
    S_LEFTOVER,
    S_CARVE,
    S_BORROW,
    S_BORROW_RD,
    S_BORROW_WB,
    S_DIV,
    S_THREAD,
    S_CLEAR,
    S_DONE
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;     // latch the input transaction
    logic push_free;   // push freed block onto its class list
    logic pop_rd;      // read link of class head
    logic pop_wb;      // head <= link, result <= old head
    logic leftover;    // push chunk leftover
    logic carve;       // take fresh chunk from pool
    logic scan_init;   // start borrow scan at request class
    logic scan_next;   // advance borrow scan
    logic borrow_rd;   // read link of borrowed head
    logic borrow_wb;   // pop borrowed block into chunk
    logic oom;         // empty chunk, flag out of memory
    logic div_init;    // start objects-per-chunk division
    logic div_step;    // one division step
    logic thread_init; // take first object, set list head
    logic thread_step; // write one link
    logic clear;       // empty all state
    logic emit;        // load result into output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bad_size;
    logic head_valid;
    logic left_short;
    logic left_nonzero;
    logic pool_fits;
    logic scan_hit;
    logic scan_last;
    logic div_done;
    logic thread_last;
    logic multi;
  } stat_t;

endpackage

FILE: sv/size_class_pool_allocator.sv
// Top level: size-class pool allocator, one transaction at a time.
// Alloc pops the class list when it is not empty; otherwise it refills the class from
// the current chunk, or pushes the chunk leftover and carves a fresh chunk from the pool,
// or borrows a block from the first non-empty class from the request class up. The
// divider gives n objects, then one link write a cycle; if no class lends, out of memory.
// Throughput: next accept the cycle after the result enters the output register.
// Reset: asynchronous; all class lists empty, chunk and pool cleared; link memory unset.
module size_class_pool_allocator #(
  parameter int ALIGN_BYTES     = 8,
  parameter int MAX_SMALL_BYTES = 128,
  parameter int POOL_BYTES      = 65536,
  parameter int REFILL_OBJECTS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] size_bytes_i,
  input  logic [15:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_address_o,
  output logic [1:0]  status_o
);

  scpa_pkg::cmd_t  cmd;
  scpa_pkg::stat_t stat;

  scpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  scpa_dp #(
    .ALIGN_BYTES     (ALIGN_BYTES),
    .MAX_SMALL_BYTES (MAX_SMALL_BYTES),
    .POOL_BYTES      (POOL_BYTES),
    .REFILL_OBJECTS  (REFILL_OBJECTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op_i),
    .size_bytes_i     (size_bytes_i),
    .block_address_i  (block_address_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .result_address_o (result_address_o),
    .status_o         (status_o)
  );

endmodule

FILE: sv/scpa_ctrl.sv
// Controller state machine for the size-class pool allocator.
module scpa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output scpa_pkg::cmd_t   cmd_o,
  input  scpa_pkg::stat_t  stat_i
);

  scpa_pkg::state_e state_q, state_d;
  logic [1:0]       op_q;
  logic             out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      scpa_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) state_d = scpa_pkg::S_DECODE;
      end
      scpa_pkg::S_DECODE: begin
        case (op_q)
          scpa_pkg::OP_ALLOC: begin
            if (stat_i.bad_size) state_d = scpa_pkg::S_DONE;
            else if (stat_i.head_valid) state_d = scpa_pkg::S_POP_RD;
            else if (stat_i.left_short) state_d = scpa_pkg::S_LEFTOVER;
            else state_d = scpa_pkg::S_DIV;
          end
          scpa_pkg::OP_FREE:  state_d = scpa_pkg::S_DONE;
          scpa_pkg::OP_CLEAR: state_d = scpa_pkg::S_DONE;
          default:            state_d = scpa_pkg::S_DONE;
        endcase
      end
      scpa_pkg::S_POP_RD: state_d = scpa_pkg::S_POP_WB;
      scpa_pkg::S_POP_WB: state_d = scpa_pkg::S_DONE;
      scpa_pkg::S_LEFTOVER: state_d = scpa_pkg::S_CARVE;
      scpa_pkg::S_CARVE: begin
        if (stat_i.pool_fits) state_d = scpa_pkg::S_DIV;
        else state_d = scpa_pkg::S_BORROW;
      end
      scpa_pkg::S_BORROW: begin
        if (stat_i.scan_hit) state_d = scpa_pkg::S_BORROW_RD;
        else if (stat_i.scan_last) state_d = scpa_pkg::S_DONE;
      end
      scpa_pkg::S_BORROW_RD: state_d = scpa_pkg::S_BORROW_WB;
      scpa_pkg::S_BORROW_WB: state_d = scpa_pkg::S_DIV;
      scpa_pkg::S_DIV: begin
        if (stat_i.div_done) state_d = scpa_pkg::S_THREAD;
      end
      scpa_pkg::S_THREAD: begin
        if (stat_i.thread_last) state_d = scpa_pkg::S_DONE;
      end
      scpa_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = scpa_pkg::S_IDLE;
      end
      default: state_d = scpa_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    in_ready_o  = (state_q == scpa_pkg::S_IDLE);
    case (state_q)
      scpa_pkg::S_IDLE: cmd_o.capture = in_valid_i;
      scpa_pkg::S_DECODE: begin
        case (op_q)
          scpa_pkg::OP_ALLOC: begin
            if (!stat_i.bad_size && !stat_i.head_valid && !stat_i.left_short)
              cmd_o.div_init = 1'b1;
          end
          scpa_pkg::OP_FREE:  cmd_o.push_free = !stat_i.bad_size;
          scpa_pkg::OP_CLEAR: cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      scpa_pkg::S_POP_RD: cmd_o.pop_rd = 1'b1;
      scpa_pkg::S_POP_WB: cmd_o.pop_wb = 1'b1;
      scpa_pkg::S_LEFTOVER: cmd_o.leftover = stat_i.left_nonzero;
      scpa_pkg::S_CARVE: begin
        if (stat_i.pool_fits) begin
          cmd_o.carve    = 1'b1;
          cmd_o.div_init = 1'b1;
        end else begin
          cmd_o.scan_init = 1'b1;
        end
      end
      scpa_pkg::S_BORROW: begin
        if (stat_i.scan_hit) cmd_o.borrow_rd = 1'b1;
        else if (stat_i.scan_last) cmd_o.oom = 1'b1;
        else cmd_o.scan_next = 1'b1;
      end
      scpa_pkg::S_BORROW_RD: cmd_o.borrow_rd = 1'b1;
      scpa_pkg::S_BORROW_WB: begin
        cmd_o.borrow_wb = 1'b1;
        cmd_o.div_init  = 1'b1;
      end
      scpa_pkg::S_DIV: begin
        if (stat_i.div_done) cmd_o.thread_init = 1'b1;
        else cmd_o.div_step = 1'b1;
      end
      scpa_pkg::S_THREAD: cmd_o.thread_step = 1'b1;
      scpa_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          cmd_o.emit  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scpa_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      op_q        <= scpa_pkg::OP_NONE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cmd_o.capture) op_q <= op_i;
    end
  end

  // Only one transaction in flight
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == scpa_pkg::S_IDLE)
    else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == scpa_pkg::S_DECODE)
    else $error("accept not decoded");

endmodule

FILE: sv/scpa_dp.sv
// Datapath: class heads, link memory, chunk bounds, divider and threader.
module scpa_dp #(
  parameter int ALIGN_BYTES     = 8,
  parameter int MAX_SMALL_BYTES = 128,
  parameter int POOL_BYTES      = 65536,
  parameter int REFILL_OBJECTS  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       op_i,
  input  logic [15:0]      size_bytes_i,
  input  logic [15:0]      block_address_i,
  input  scpa_pkg::cmd_t   cmd_i,
  output scpa_pkg::stat_t  stat_o,
  output logic [15:0]      result_address_o,
  output logic [1:0]       status_o
);

  localparam int NumClasses = (MAX_SMALL_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int ClsW       = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int AlignW     = $clog2(ALIGN_BYTES);
  localparam int LinkDepth  = POOL_BYTES / ALIGN_BYTES;
  localparam int SlotW      = $clog2(LinkDepth);
  localparam int CntW       = $clog2(REFILL_OBJECTS + 1);
  localparam int DivW       = 18;
  localparam logic [17:0] PoolSize = 18'(POOL_BYTES);

  // Captured request
  logic [1:0]      op_q;
  logic [15:0]     size_q, baddr_q;
  logic [ClsW-1:0] cls_q;
  logic [17:0]     osz_q;   // rounded object size

  // State
  logic [16:0]     heads_q [NumClasses];
  logic [16:0]     link_mem [LinkDepth];
  logic [16:0]     link_rd_q;
  logic [17:0]     cs_q, ce_q, pool_q;
  logic [ClsW-1:0] scan_q;
  logic [15:0]     res_q;
  logic [1:0]      st_q;
  logic [15:0]     out_addr_q;
  logic [1:0]      out_st_q;

  // Divider and threader
  logic [DivW-1:0] rem_q, quo_q;
  logic [4:0]      dcnt_q;
  logic [CntW-1:0] n_q, j_q;
  logic [CntW-1:0] n_div;
  logic [15:0]     obj_q;

  logic [17:0] left;
  logic [17:0] want;
  logic        bad;
  logic [ClsW-1:0] cls_in;
  logic [16:0] size_up;

  assign size_up = 17'(size_bytes_i) + 17'(ALIGN_BYTES - 1);
  assign cls_in  = ClsW'((size_up >> AlignW) - 17'd1);
  assign bad     = (size_q == 16'd0) || (32'(size_q) > 32'(MAX_SMALL_BYTES));
  assign left    = ce_q - cs_q;
  assign want    = 18'(osz_q * 18'(2 * REFILL_OBJECTS));
  // objects cut from the chunk, capped at the refill count
  assign n_div   = (quo_q > DivW'(REFILL_OBJECTS)) ? CntW'(REFILL_OBJECTS) : CntW'(quo_q);

  // Status to controller
  always_comb begin
    stat_o              = '0;
    stat_o.bad_size     = bad;
    stat_o.head_valid   = heads_q[cls_q][16];
    stat_o.left_short   = left < osz_q;
    stat_o.left_nonzero = left != 18'd0;
    stat_o.pool_fits    = (PoolSize - pool_q) >= want;
    stat_o.scan_hit     = heads_q[scan_q][16];
    stat_o.scan_last    = 32'(scan_q) == NumClasses - 1;
    stat_o.div_done     = dcnt_q == 5'd18;
    stat_o.thread_last  = (32'(j_q) + 1 >= 32'(n_q));
    stat_o.multi        = n_q > CntW'(1);
  end

  // Control-reset registers: heads, chunk, pool, scan, divider count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumClasses; c++) heads_q[c] <= '0;
      cs_q   <= '0;
      ce_q   <= '0;
      pool_q <= '0;
      scan_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        for (int c = 0; c < NumClasses; c++) heads_q[c] <= '0;
        cs_q   <= '0;
        ce_q   <= '0;
        pool_q <= '0;
      end
      if (cmd_i.push_free) heads_q[cls_q] <= {1'b1, baddr_q};
      if (cmd_i.pop_wb) heads_q[cls_q] <= link_rd_q;
      if (cmd_i.leftover)
        heads_q[ClsW'((left >> AlignW) - 18'd1)] <= {1'b1, cs_q[15:0]};
      if (cmd_i.carve) begin
        cs_q   <= pool_q;
        ce_q   <= pool_q + want;
        pool_q <= pool_q + want;
      end
      if (cmd_i.scan_init) scan_q <= cls_q;
      if (cmd_i.scan_next) scan_q <= scan_q + ClsW'(1);
      if (cmd_i.borrow_wb) begin
        heads_q[scan_q] <= link_rd_q;
        cs_q <= 18'(heads_q[scan_q][15:0]);
        ce_q <= 18'(heads_q[scan_q][15:0]) + 18'((32'(scan_q) + 1) * ALIGN_BYTES);
      end
      if (cmd_i.oom) begin
        cs_q <= '0;
        ce_q <= '0;
      end
      if (cmd_i.div_init) dcnt_q <= '0;
      if (cmd_i.div_step) dcnt_q <= dcnt_q + 5'd1;
      if (cmd_i.thread_init) begin
        cs_q <= cs_q + 18'(32'(n_div) * 32'(osz_q));
        if (n_div > CntW'(1))
          heads_q[cls_q] <= {1'b1, 16'(cs_q + osz_q)};
      end
    end
  end

  // Divider: restoring, one quotient bit per cycle; dividend latched at div_init
  logic [DivW-1:0] dvd_q;
  logic [DivW:0]   trial;
  assign trial = {rem_q, dvd_q[DivW-1]} - {1'b0, osz_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      size_q  <= size_bytes_i;
      baddr_q <= block_address_i;
      cls_q   <= cls_in;
      osz_q   <= 18'((32'(cls_in) + 1) * ALIGN_BYTES);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
      if (cmd_i.carve) dvd_q <= want;
      else if (cmd_i.borrow_wb) dvd_q <= 18'((32'(scan_q) + 1) * ALIGN_BYTES);
      else dvd_q <= left;
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      if (!trial[DivW]) begin
        rem_q <= trial[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DivW-2:0], dvd_q[DivW-1]};
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_init) n_q <= '0;
    else if (cmd_i.thread_init) n_q <= n_div;
    if (cmd_i.thread_init) begin
      j_q   <= CntW'(1);
      obj_q <= 16'(cs_q + osz_q);
      res_q <= cs_q[15:0];
    end
    if (cmd_i.thread_step) begin
      j_q   <= j_q + CntW'(1);
      obj_q <= obj_q + osz_q[15:0];
    end
    if (cmd_i.pop_wb) res_q <= heads_q[cls_q][15:0];
    if (cmd_i.capture) begin
      res_q <= '0;
      st_q  <= scpa_pkg::ST_OK;
    end
    if (cmd_i.oom) res_q <= '0;
    if (cmd_i.oom) st_q <= scpa_pkg::ST_OOM;
    if ((op_q == scpa_pkg::OP_ALLOC || op_q == scpa_pkg::OP_FREE) && bad && !cmd_i.capture)
      st_q <= scpa_pkg::ST_BADSZ;
  end

  // Output register: holds the result while the next transaction runs
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_addr_q <= res_q;
      out_st_q   <= st_q;
    end
  end

  // Link memory: one write and one registered read port
  logic             lk_we;
  logic [SlotW-1:0] lk_wa, lk_ra;
  logic [16:0]      lk_wd;
  always_comb begin
    lk_we = 1'b0;
    lk_wa = baddr_q[AlignW +: SlotW];
    lk_wd = heads_q[cls_q];
    lk_ra = heads_q[cls_q][AlignW +: SlotW];
    if (cmd_i.borrow_rd) lk_ra = heads_q[scan_q][AlignW +: SlotW];
    if (cmd_i.push_free) lk_we = 1'b1;
    if (cmd_i.leftover) begin
      lk_we = 1'b1;
      lk_wa = cs_q[AlignW +: SlotW];
      lk_wd = heads_q[ClsW'((left >> AlignW) - 18'd1)];
    end
    if (cmd_i.thread_step && stat_o.multi) begin
      lk_we = 1'b1;
      lk_wa = obj_q[AlignW +: SlotW];
      lk_wd = stat_o.thread_last ? 17'd0 : {1'b1, obj_q + osz_q[15:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    link_rd_q <= link_mem[lk_ra];
  end

  assign result_address_o = out_addr_q;
  assign status_o         = out_st_q;

  a_oom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.oom |=> cs_q == 18'd0 && ce_q == 18'd0)
    else $error("oom chunk not emptied");
  a_chunk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.carve |=> ce_q >= cs_q)
    else $error("chunk bounds crossed");
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_q <= PoolSize)
    else $error("pool overrun");

endmodule
